[hw/rtl/dwrs_pkg.sv]
// dwrs_pkg: shared types and constants of the deque with reverse and split
// no dependencies; imported by the interfaces, the controller and the top level
`default_nettype none

package dwrs_pkg;

  localparam int ACTION_W = 3;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_TOP    = 3'd0,
    ACT_PUSH_BOTTOM = 3'd1,
    ACT_POP_TOP     = 3'd2,
    ACT_POP_BOTTOM  = 3'd3,
    ACT_REVERSE     = 3'd4,
    ACT_SPLIT       = 3'd5
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_POP   = 2'd1,
    S_SPLIT = 2'd2,
    S_HOLD  = 2'd3
  } state_e;

endpackage

`default_nettype wire

[hw/rtl/dwrs_if.sv]
// dwrs_in_if / dwrs_out_if: valid/ready channels for requests and results
// depends on dwrs_pkg for the field widths
`default_nettype none

interface dwrs_in_if;
  logic                                valid;
  logic                                ready;
  logic [dwrs_pkg::ACTION_W-1:0]       action;
  logic signed [dwrs_pkg::WORD_W-1:0]  value;
  logic signed [dwrs_pkg::WORD_W-1:0]  threshold;

  modport source (output valid, action, value, threshold, input ready);
  modport sink (input valid, action, value, threshold, output ready);
endinterface

interface dwrs_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [dwrs_pkg::WORD_W-1:0]  popped;
  logic [dwrs_pkg::STATUS_W-1:0]       status;
  logic [dwrs_pkg::COUNT_W-1:0]        count;

  modport source (output valid, popped, status, count, input ready);
  modport sink (input valid, popped, status, count, output ready);
endinterface

`default_nettype wire

[hw/rtl/dwrs_store.sv]
// dwrs_store: one word store, one write port and one registered read port
// no dependencies; instantiated twice by the top level
`default_nettype none

module dwrs_store #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32,
  localparam int AW        = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [DATA_WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]         raddr_i,
  output logic [DATA_WIDTH-1:0] rdata_o
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/dwrs_ctrl.sv]
// dwrs_ctrl: sequencer, index registers, split walk and result register
// depends on dwrs_pkg and dwrs_if; drives the store ports of the top level
`default_nettype none

module dwrs_ctrl #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32,
  localparam int AW        = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  dwrs_in_if.sink               req_i,
  dwrs_out_if.source            rsp_o,
  output logic                  wr_en_o,
  output logic                  wr_sel_o,
  output logic [AW-1:0]         wr_addr_o,
  output logic [DATA_WIDTH-1:0] wr_data_o,
  output logic [AW-1:0]         rd_addr_o,
  input  logic [DATA_WIDTH-1:0] rd_data_i,
  output logic                  active_o
);

  import dwrs_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int VW = (DATA_WIDTH > WORD_W) ? DATA_WIDTH : WORD_W;

  function automatic logic [AW-1:0] slot_fwd(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= SW'(DEPTH)) s = s - SW'(DEPTH);
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] slot_bwd(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(DEPTH) - SW'(off);
    if (s >= SW'(DEPTH)) s = s - SW'(DEPTH);
    return s[AW-1:0];
  endfunction

  state_e                  state_q, state_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [AW-1:0]           top_q, top_d;
  logic                    rev_q, rev_d;
  logic                    act_q, act_d;
  logic [AW-1:0]           sp_ptr_q, sp_ptr_d;
  logic [CW-1:0]           sp_i_q, sp_i_d;
  logic                    sp_pass_q, sp_pass_d;
  logic                    sp_vld_q, sp_vld_d;
  logic                    sp_tag_q, sp_tag_d;
  logic [AW-1:0]           sp_n_q, sp_n_d;
  logic signed [WORD_W-1:0] thr_q, thr_d;
  logic [WORD_W-1:0]       res_popped_q, res_popped_d;
  status_e                 res_status_q, res_status_d;
  logic [COUNT_W-1:0]      res_count_q, res_count_d;
  logic                    out_vld_q, out_vld_d;
  logic [WORD_W-1:0]       out_popped_q, out_popped_d;
  status_e                 out_status_q, out_status_d;
  logic [COUNT_W-1:0]      out_count_q, out_count_d;

  action_e                 op;
  logic                    acc, full, empty, slot_free, split_end, big;
  logic [CW-1:0]           cnt_m1, off_sel;
  logic [AW-1:0]           s_back, s_off, pop_slot, ptr_step;
  logic signed [VW-1:0]    rd_sx, thr_sx;
  logic [VW-1:0]           val_zx;
  logic                    fin;
  logic [WORD_W-1:0]       fin_popped;
  status_e                 fin_status;

  assign op        = action_e'(req_i.action);
  assign acc       = req_i.valid && req_i.ready;
  assign full      = (cnt_q == CW'(DEPTH));
  assign empty     = (cnt_q == '0);
  assign cnt_m1    = cnt_q - CW'(1);
  assign slot_free = !out_vld_q || rsp_o.ready;
  assign split_end = (state_q == S_SPLIT) && (sp_i_q == cnt_q) && sp_pass_q && !sp_vld_q;

  assign rd_sx  = VW'($signed(rd_data_i));
  assign thr_sx = VW'(thr_q);
  assign big    = (rd_sx >= thr_sx);
  assign val_zx = VW'($unsigned(req_i.value));

  // slot arithmetic
  assign s_back = rev_q ? slot_fwd(top_q, CW'(1)) : slot_bwd(top_q, CW'(1));

  always_comb begin
    case (op)
      ACT_POP_TOP:     off_sel = CW'(1);
      ACT_PUSH_BOTTOM: off_sel = cnt_q;
      default:         off_sel = cnt_m1;
    endcase
  end

  assign s_off    = rev_q ? slot_bwd(top_q, off_sel) : slot_fwd(top_q, off_sel);
  assign pop_slot = (op == ACT_POP_TOP) ? top_q : s_off;

  always_comb begin
    if (rev_q) begin
      ptr_step = (sp_ptr_q == '0) ? AW'(DEPTH - 1) : sp_ptr_q - AW'(1);
    end else begin
      ptr_step = (sp_ptr_q == AW'(DEPTH - 1)) ? '0 : sp_ptr_q + AW'(1);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          if ((op == ACT_POP_TOP || op == ACT_POP_BOTTOM) && !empty) begin
            state_d = S_POP;
          end else if (op == ACT_SPLIT) begin
            state_d = S_SPLIT;
          end else if (!slot_free) begin
            state_d = S_HOLD;
          end
        end
      end
      S_POP: begin
        state_d = slot_free ? S_IDLE : S_HOLD;
      end
      S_SPLIT: begin
        if (split_end) begin
          state_d = slot_free ? S_IDLE : S_HOLD;
        end
      end
      S_HOLD: begin
        if (slot_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_d      = cnt_q;
    top_d      = top_q;
    rev_d      = rev_q;
    act_d      = act_q;
    sp_ptr_d   = sp_ptr_q;
    sp_i_d     = sp_i_q;
    sp_pass_d  = sp_pass_q;
    sp_vld_d   = 1'b0;
    sp_tag_d   = sp_tag_q;
    sp_n_d     = sp_n_q;
    thr_d      = thr_q;
    wr_en_o    = 1'b0;
    wr_sel_o   = act_q;
    wr_addr_o  = s_off;
    wr_data_o  = val_zx[DATA_WIDTH-1:0];
    rd_addr_o  = sp_ptr_q;
    fin        = 1'b0;
    fin_popped = '0;
    fin_status = STAT_OK;

    case (state_q)
      S_IDLE: begin
        rd_addr_o = pop_slot;
        if (acc) begin
          case (op)
            ACT_PUSH_TOP, ACT_PUSH_BOTTOM: begin
              fin = 1'b1;
              if (full) begin
                fin_status = STAT_FULL;
              end else begin
                wr_en_o = 1'b1;
                cnt_d   = cnt_q + CW'(1);
                if (op == ACT_PUSH_TOP) begin
                  if (!empty) top_d = s_back;
                  wr_addr_o = empty ? top_q : s_back;
                end
              end
            end
            ACT_POP_TOP, ACT_POP_BOTTOM: begin
              if (empty) begin
                fin        = 1'b1;
                fin_status = STAT_EMPTY;
              end else begin
                cnt_d = cnt_m1;
                if (op == ACT_POP_TOP) top_d = s_off;
              end
            end
            ACT_REVERSE: begin
              fin = 1'b1;
              if (!empty) top_d = s_off;
              rev_d = ~rev_q;
            end
            ACT_SPLIT: begin
              sp_ptr_d  = top_q;
              sp_i_d    = '0;
              sp_pass_d = 1'b0;
              sp_n_d    = '0;
              thr_d     = req_i.threshold;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        fin        = 1'b1;
        fin_popped = rd_sx[WORD_W-1:0];
      end
      S_SPLIT: begin
        if (sp_i_q != cnt_q) begin
          sp_ptr_d = ptr_step;
          sp_i_d   = sp_i_q + CW'(1);
          sp_vld_d = 1'b1;
          sp_tag_d = sp_pass_q;
        end else if (!sp_pass_q) begin
          sp_pass_d = 1'b1;
          sp_i_d    = '0;
          sp_ptr_d  = top_q;
        end
        if (sp_vld_q && (big == !sp_tag_q)) begin
          wr_en_o   = 1'b1;
          wr_sel_o  = ~act_q;
          wr_addr_o = sp_n_q;
          wr_data_o = rd_data_i;
          sp_n_d    = sp_n_q + AW'(1);
        end
        if (split_end) begin
          fin   = 1'b1;
          top_d = '0;
          rev_d = 1'b0;
          act_d = ~act_q;
        end
      end
      S_HOLD: begin
      end
      default: begin
      end
    endcase

    res_popped_d = fin ? fin_popped : res_popped_q;
    res_status_d = fin ? fin_status : res_status_q;
    res_count_d  = fin ? COUNT_W'(cnt_d) : res_count_q;

    out_popped_d = out_popped_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    out_vld_d    = rsp_o.ready ? 1'b0 : out_vld_q;
    if (fin && slot_free) begin
      out_vld_d    = 1'b1;
      out_popped_d = fin_popped;
      out_status_d = fin_status;
      out_count_d  = COUNT_W'(cnt_d);
    end else if (state_q == S_HOLD && slot_free) begin
      out_vld_d    = 1'b1;
      out_popped_d = res_popped_q;
      out_status_d = res_status_q;
      out_count_d  = res_count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      top_q     <= '0;
      rev_q     <= 1'b0;
      act_q     <= 1'b0;
      sp_vld_q  <= 1'b0;
      sp_pass_q <= 1'b0;
      sp_i_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      top_q     <= top_d;
      rev_q     <= rev_d;
      act_q     <= act_d;
      sp_vld_q  <= sp_vld_d;
      sp_pass_q <= sp_pass_d;
      sp_i_q    <= sp_i_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sp_ptr_q     <= sp_ptr_d;
    sp_tag_q     <= sp_tag_d;
    sp_n_q       <= sp_n_d;
    thr_q        <= thr_d;
    res_popped_q <= res_popped_d;
    res_status_q <= res_status_d;
    res_count_q  <= res_count_d;
    out_popped_q <= out_popped_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
  end

  assign req_i.ready  = (state_q == S_IDLE);
  assign rsp_o.valid  = out_vld_q;
  assign rsp_o.popped = out_popped_q;
  assign rsp_o.status = out_status_q;
  assign rsp_o.count  = out_count_q;
  assign active_o     = act_q;

endmodule

`default_nettype wire

[hw/rtl/deque_with_reverse_and_split_unit.sv]
// Bounded double-ended queue of DEPTH words of DATA_WIDTH bits, kept in two
// one-port-read, one-port-write stores with a registered read. One request
// transaction gives one result transaction holding the popped word, a status
// and the element count. Push, reverse, unused actions and a pop on an empty
// deque finish in the cycle they are accepted; a pop of a held word waits for
// the store read; a split streams the held elements twice out of the active
// store, one read a cycle, writing first those at or above the threshold and
// then the rest into the other store, then swaps the stores. req_i.ready is
// low while a pop or split is in work or while a finished result waits
// behind a full result register.
// No clearing pass after reset: unwritten store entries are never read.
// Depends on dwrs_pkg, dwrs_if, dwrs_store and dwrs_ctrl.
`default_nettype none

module deque_with_reverse_and_split_unit #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dwrs_in_if.sink    req_i,
  dwrs_out_if.source rsp_o
);

  import dwrs_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic                  wr_en, wr_sel, active;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [DATA_WIDTH-1:0] wr_data, rd_data, rd_data0, rd_data1;
  logic                  we0, we1;

  assign we0     = wr_en && !wr_sel;
  assign we1     = wr_en && wr_sel;
  assign rd_data = active ? rd_data1 : rd_data0;

  dwrs_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .rsp_o     (rsp_o),
    .wr_en_o   (wr_en),
    .wr_sel_o  (wr_sel),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .active_o  (active)
  );

  dwrs_store #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store0 (
    .clk_i   (clk_i),
    .we_i    (we0),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data0)
  );

  dwrs_store #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store1 (
    .clk_i   (clk_i),
    .we_i    (we1),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data1)
  );

endmodule

`default_nettype wire
